>>> hdl/cmuv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmuv_pkg
// Shared types and constants of the cube map face and UV projection block.
// ----------------------------------------------------------------------------
package cmuv_pkg;

  // width of each position field on the input channel
  localparam int POS_W = 32;
  localparam int FACE_W = 3;

  // restoring divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS_PER_STAGE = 2;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  typedef struct packed {
    face_e face;
    logic  degen;
  } side_t;

endpackage
`default_nettype wire

>>> hdl/cmuv_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmuv_intf
// Valid/ready channels: vertex positions in, face and UV coordinates out.
// ----------------------------------------------------------------------------
interface cmuv_pos_if;
  logic                               valid;
  logic                               ready;
  logic signed [cmuv_pkg::POS_W-1:0]  pos_x;
  logic signed [cmuv_pkg::POS_W-1:0]  pos_y;
  logic signed [cmuv_pkg::POS_W-1:0]  pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface cmuv_uv_if #(
  parameter int UV_W = 16
);
  logic                  valid;
  logic                  ready;
  logic [UV_W-1:0]       u_coord;
  logic [UV_W-1:0]       v_coord;
  cmuv_pkg::face_e       face;
  logic                  degenerate;

  modport source (output valid, output u_coord, output v_coord, output face,
                  output degenerate, input ready);
  modport sink   (input valid, input u_coord, input v_coord, input face,
                  input degenerate, output ready);
endinterface
`default_nettype wire

>>> hdl/cmuv_face_sel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmuv_face_sel
// Three stages: truncate or zero extend and magnitude, dominant axis and
// face pick, numerator and denominator forming for the UV divider.
// ----------------------------------------------------------------------------
module cmuv_face_sel #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [cmuv_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [cmuv_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [cmuv_pkg::POS_W-1:0]  pos_z_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [COORD_WIDTH:0]               num_u_o,
  output logic [COORD_WIDTH:0]               num_v_o,
  output logic [COORD_WIDTH:0]               den_o,
  output cmuv_pkg::side_t                    side_o
);
  import cmuv_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [2:0] vld_q;
  logic [2:0] en;

  assign en[2]   = !vld_q[2] || ready_i;
  assign en[1]   = !vld_q[1] || en[2];
  assign en[0]   = !vld_q[0] || en[1];
  assign ready_o = en[0];
  assign valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage A: take the low CW bits or zero extend to CW, magnitude
  logic [CW-1:0] x_raw, y_raw, z_raw;

  if (CW <= POS_W) begin : g_trunc
    assign x_raw = pos_x_i[CW-1:0];
    assign y_raw = pos_y_i[CW-1:0];
    assign z_raw = pos_z_i[CW-1:0];
  end else begin : g_ext
    assign x_raw = {{(CW-POS_W){1'b0}}, pos_x_i};
    assign y_raw = {{(CW-POS_W){1'b0}}, pos_y_i};
    assign z_raw = {{(CW-POS_W){1'b0}}, pos_z_i};
  end

  logic [CW-1:0] ax_d, ay_d, az_d;
  logic [CW-1:0] x_q, y_q, z_q, ax_q, ay_q, az_q;
  logic          px_q, py_q, pz_q;

  assign ax_d = x_raw[CW-1] ? (~x_raw + 1'b1) : x_raw;
  assign ay_d = y_raw[CW-1] ? (~y_raw + 1'b1) : y_raw;
  assign az_d = z_raw[CW-1] ? (~z_raw + 1'b1) : z_raw;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q  <= x_raw;
      y_q  <= y_raw;
      z_q  <= z_raw;
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
      px_q <= !x_raw[CW-1] && (|x_raw);
      py_q <= !y_raw[CW-1] && (|y_raw);
      pz_q <= !z_raw[CW-1] && (|z_raw);
    end
  end

  // stage B: dominant axis, ties to Z then Y, zero counts as negative
  logic          z_win, y_win;
  face_e         face_d, face_q;
  logic [CW-1:0] m_d, m_q, cu_d, cu_q, cv_d, cv_q;
  logic          neg_u_d, neg_u_q, neg_v_d, neg_v_q, degen_q;

  assign z_win = (az_q >= ax_q) && (az_q >= ay_q);
  assign y_win = (ay_q >= ax_q);

  always_comb begin
    face_d  = FACE_NEG_Z;
    m_d     = az_q;
    cu_d    = x_q;
    cv_d    = y_q;
    neg_u_d = 1'b0;
    neg_v_d = 1'b0;
    if (z_win) begin
      m_d = az_q;
      if (pz_q) begin
        face_d = FACE_POS_Z;
      end else begin
        face_d  = FACE_NEG_Z;
        neg_u_d = 1'b1;
      end
    end else if (y_win) begin
      m_d  = ay_q;
      cv_d = z_q;
      if (py_q) begin
        face_d  = FACE_POS_Y;
        neg_v_d = 1'b1;
      end else begin
        face_d = FACE_NEG_Y;
      end
    end else begin
      m_d  = ax_q;
      cu_d = z_q;
      if (px_q) begin
        face_d  = FACE_POS_X;
        neg_u_d = 1'b1;
      end else begin
        face_d = FACE_NEG_X;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      face_q  <= face_d;
      m_q     <= m_d;
      cu_q    <= cu_d;
      cv_q    <= cv_d;
      neg_u_q <= neg_u_d;
      neg_v_q <= neg_v_d;
      degen_q <= !(|ax_q) && !(|ay_q) && !(|az_q);
    end
  end

  // stage C: n = m +/- c in 0..2m, d = 2m
  logic [CW:0] cu_ext, cv_ext, m_ext;
  logic [CW:0] num_u_q, num_v_q, den_q;
  side_t       side_q;

  assign cu_ext = {cu_q[CW-1], cu_q};
  assign cv_ext = {cv_q[CW-1], cv_q};
  assign m_ext  = {1'b0, m_q};

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      num_u_q      <= neg_u_q ? (m_ext - cu_ext) : (m_ext + cu_ext);
      num_v_q      <= neg_v_q ? (m_ext - cv_ext) : (m_ext + cv_ext);
      den_q        <= {m_q, 1'b0};
      side_q.face  <= face_q;
      side_q.degen <= degen_q;
    end
  end

  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

>>> hdl/cmuv_uv_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmuv_uv_div
// Pipelined restoring divider, two lanes on a shared denominator, with a
// final round-half-up, saturate and degenerate override stage.
// ----------------------------------------------------------------------------
module cmuv_uv_div #(
  parameter int COORD_WIDTH  = 32,
  parameter int UV_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [COORD_WIDTH:0]      num_u_i,
  input  logic [COORD_WIDTH:0]      num_v_i,
  input  logic [COORD_WIDTH:0]      den_i,
  input  cmuv_pkg::side_t           side_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [UV_FRAC_BITS-1:0]   u_o,
  output logic [UV_FRAC_BITS-1:0]   v_o,
  output cmuv_pkg::side_t           side_o
);
  import cmuv_pkg::*;

  localparam int RW    = COORD_WIDTH + 1;
  localparam int QW    = UV_FRAC_BITS + 1;
  localparam int NSTEP = UV_FRAC_BITS + 1;
  localparam int SPS   = DIV_STEPS_PER_STAGE;
  localparam int NST   = (NSTEP + SPS - 1) / SPS;
  localparam logic [UV_FRAC_BITS-1:0] UV_HALF = {1'b1, {(UV_FRAC_BITS-1){1'b0}}};
  localparam logic [UV_FRAC_BITS-1:0] UV_MAX  = '1;

  // index NST is the output register
  logic [NST:0] vld_q;
  logic [NST:0] en;

  assign en[NST] = !vld_q[NST] || ready_i;
  for (genvar s = 0; s < NST; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end
  assign ready_o = en[0];
  assign valid_o = vld_q[NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int s = 1; s <= NST; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  logic [RW-1:0] rem_u_q [NST];
  logic [RW-1:0] rem_v_q [NST];
  logic [QW-1:0] q_u_q   [NST];
  logic [QW-1:0] q_v_q   [NST];
  logic [RW-1:0] den_q   [NST];
  side_t         side_q  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [RW-1:0] ru_in, rv_in, dn_in;
    logic [QW-1:0] qu_in, qv_in;
    side_t         sd_in;
    logic [RW-1:0] ru_d, rv_d;
    logic [QW-1:0] qu_d, qv_d;

    if (s == 0) begin : g_first
      assign ru_in = num_u_i;
      assign rv_in = num_v_i;
      assign qu_in = '0;
      assign qv_in = '0;
      assign dn_in = den_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign ru_in = rem_u_q[s-1];
      assign rv_in = rem_v_q[s-1];
      assign qu_in = q_u_q[s-1];
      assign qv_in = q_v_q[s-1];
      assign dn_in = den_q[s-1];
      assign sd_in = side_q[s-1];
    end

    always_comb begin
      ru_d = ru_in;
      rv_d = rv_in;
      qu_d = qu_in;
      qv_d = qv_in;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < NSTEP) begin
          if (s * SPS + j > 0) begin
            ru_d = {ru_d[RW-2:0], 1'b0};
            rv_d = {rv_d[RW-2:0], 1'b0};
          end
          qu_d = {qu_d[QW-2:0], 1'b0};
          qv_d = {qv_d[QW-2:0], 1'b0};
          if (ru_d >= dn_in) begin
            ru_d    = ru_d - dn_in;
            qu_d[0] = 1'b1;
          end
          if (rv_d >= dn_in) begin
            rv_d    = rv_d - dn_in;
            qv_d[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rem_u_q[s] <= ru_d;
        rem_v_q[s] <= rv_d;
        q_u_q[s]   <= qu_d;
        q_v_q[s]   <= qv_d;
        den_q[s]   <= dn_in;
        side_q[s]  <= sd_in;
      end
    end
  end

  // round half up, saturate, degenerate override
  logic          rnd_u, rnd_v;
  logic [QW-1:0] qr_u, qr_v;
  logic [UV_FRAC_BITS-1:0] u_d, v_d, u_q, v_q;
  side_t         side_out_q;

  assign rnd_u = {rem_u_q[NST-1], 1'b0} >= {1'b0, den_q[NST-1]};
  assign rnd_v = {rem_v_q[NST-1], 1'b0} >= {1'b0, den_q[NST-1]};
  assign qr_u  = q_u_q[NST-1] + {{(QW-1){1'b0}}, rnd_u};
  assign qr_v  = q_v_q[NST-1] + {{(QW-1){1'b0}}, rnd_v};

  always_comb begin
    if (side_q[NST-1].degen) begin
      u_d = UV_HALF;
      v_d = UV_HALF;
    end else begin
      u_d = qr_u[QW-1] ? UV_MAX : qr_u[UV_FRAC_BITS-1:0];
      v_d = qr_v[QW-1] ? UV_MAX : qr_v[UV_FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST]) begin
      u_q        <= u_d;
      v_q        <= v_d;
      side_out_q <= side_q[NST-1];
    end
  end

  assign u_o    = u_q;
  assign v_o    = v_q;
  assign side_o = side_out_q;

endmodule
`default_nettype wire

>>> hdl/cube_map_uv_projection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cube_map_uv_projection
// Cube face of the dominant axis and (c/max + 1)/2 texture coordinates in
// unsigned Q0.UV_FRAC_BITS for one vertex position per transaction.
//
//   channel  dir  payload                                   handshake
//   pos_i    in   pos_x, pos_y, pos_z (signed 32 each)       valid/ready
//   uv_o     out  u_coord, v_coord, face, degenerate         valid/ready
//
// One transaction per cycle sustained while uv_o is not stalled. The pipe
// holds three face-select stages, the divider stages that resolve up to two
// quotient bits each, and the rounding/output register.
// Reset clears only the per-stage valid bits; no clearing pass.
// Each stage loads when empty or when the stage after it moves, so a stall
// on uv_o backs up stage by stage and pos_i.ready stays high while bubbles
// remain.
// ----------------------------------------------------------------------------
module cube_map_uv_projection #(
  parameter int COORD_WIDTH  = 32,
  parameter int UV_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmuv_pos_if.sink    pos_i,
  cmuv_uv_if.source   uv_o
);
  import cmuv_pkg::*;

  localparam logic [UV_FRAC_BITS-1:0] UV_HALF = {1'b1, {(UV_FRAC_BITS-1){1'b0}}};

  logic                    fs_valid, fs_ready;
  logic [COORD_WIDTH:0]    num_u, num_v, den;
  side_t                   fs_side;
  logic [UV_FRAC_BITS-1:0] u_w, v_w;
  side_t                   out_side;

  cmuv_face_sel #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_face_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pos_i.valid),
    .ready_o (pos_i.ready),
    .pos_x_i (pos_i.pos_x),
    .pos_y_i (pos_i.pos_y),
    .pos_z_i (pos_i.pos_z),
    .valid_o (fs_valid),
    .ready_i (fs_ready),
    .num_u_o (num_u),
    .num_v_o (num_v),
    .den_o   (den),
    .side_o  (fs_side)
  );

  cmuv_uv_div #(
    .COORD_WIDTH  (COORD_WIDTH),
    .UV_FRAC_BITS (UV_FRAC_BITS)
  ) u_uv_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fs_valid),
    .ready_o (fs_ready),
    .num_u_i (num_u),
    .num_v_i (num_v),
    .den_i   (den),
    .side_i  (fs_side),
    .valid_o (uv_o.valid),
    .ready_i (uv_o.ready),
    .u_o     (u_w),
    .v_o     (v_w),
    .side_o  (out_side)
  );

  assign uv_o.u_coord    = u_w;
  assign uv_o.v_coord    = v_w;
  assign uv_o.face       = out_side.face;
  assign uv_o.degenerate = out_side.degen;

  // zero vector resolves to -Z by the tie and zero rules
  a_degen_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uv_o.valid && uv_o.degenerate |-> uv_o.face == FACE_NEG_Z)
    else $error("degenerate transaction not on -Z face");

  a_degen_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uv_o.valid && uv_o.degenerate |-> uv_o.u_coord == UV_HALF && uv_o.v_coord == UV_HALF)
    else $error("degenerate transaction without half coordinates");

  // input back-pressure only when the whole pipe is full and the output stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_i.ready |-> uv_o.valid && !uv_o.ready)
    else $error("input stalled while the output is free");

endmodule
`default_nettype wire
